[design/pfc_pkg.sv]
// playfair digraph cipher package: letter codes, command codes, fsm states
// and the command/status structs shared by the controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

   localparam int GRID_SIDE_DEFAULT = 5;
   localparam int LETTER_W          = 5;
   localparam int ALPHA             = 26;

   localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
   localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
   localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
   localparam logic [LETTER_W-1:0] CODE_Z = 5'd25;

   typedef enum logic [1:0] {
      CMD_KEY     = 2'd0,
      CMD_FINISH  = 2'd1,
      CMD_ENCRYPT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CELL,
      ST_SEND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic key_en;
      logic lookup_en;
      logic cell_en;
      logic fin_start;
      logic fin_step;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic complete;
      logic fin_last;
   } dp_status_type;

   function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] code);
      logic [LETTER_W-1:0] c;
      c = (code > CODE_Z) ? CODE_Z : code;
      if (c == CODE_J) begin
         c = CODE_I;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[design/playfair_digraph_cipher.sv]
// playfair digraph cipher top level: controller and datapath
// depends on pfc_pkg, pfc_ctrl, pfc_datapath
//
//   channel  direction  word
//   req_     in         command, letter_a, letter_b, second_present
//   rsp_     out        cipher_a, cipher_b, status (encrypt only)
//
// key letter: taken in idle; finish: a start, then a walk over the alphabet
// through the single write port of the square and position memories
// encrypt: position read, cell read, result load
// one command at a time; a result may wait in the output register while the
// next command is taken, and an encrypt then holds until it is drained
// synchronous reset clears the placed flags, fill count and completion flag
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher #(
   parameter int GRID_SIDE = pfc_pkg::GRID_SIDE_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_command,
   input  wire logic [pfc_pkg::LETTER_W-1:0] req_letter_a,
   input  wire logic [pfc_pkg::LETTER_W-1:0] req_letter_b,
   input  wire logic                         req_second_present,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [pfc_pkg::LETTER_W-1:0]      rsp_cipher_a,
   output logic [pfc_pkg::LETTER_W-1:0]      rsp_cipher_b,
   output logic                              rsp_status
);

   pfc_pkg::ctl_cmd_type   ctl;
   pfc_pkg::dp_status_type status;

   pfc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .ctl         (ctl)
   );

   pfc_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_letter_a       (req_letter_a),
      .req_letter_b       (req_letter_b),
      .req_second_present (req_second_present),
      .status             (status),
      .rsp_cipher_a       (rsp_cipher_a),
      .rsp_cipher_b       (rsp_cipher_b),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire

[design/pfc_ctrl.sv]
// playfair controller: sequences key, finish and encrypt commands and owns
// the result valid flag; depends on pfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_command,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire pfc_pkg::dp_status_type status,
   output pfc_pkg::ctl_cmd_type       ctl
);

   pfc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pfc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               priority if (req_command == pfc_pkg::CMD_KEY) begin
                  ctl.key_en = 1'b1;
               end else if (req_command == pfc_pkg::CMD_FINISH) begin
                  if (!status.complete) begin
                     ctl.fin_start = 1'b1;
                     state_in      = pfc_pkg::ST_FINISH;
                  end
               end else if (req_command == pfc_pkg::CMD_ENCRYPT) begin
                  ctl.lookup_en = 1'b1;
                  state_in      = pfc_pkg::ST_CELL;
               end else begin
                  state_in = pfc_pkg::ST_IDLE;
               end
            end
         end
         pfc_pkg::ST_FINISH: begin
            ctl.fin_step = 1'b1;
            if (status.fin_last) begin
               state_in = pfc_pkg::ST_IDLE;
            end
         end
         pfc_pkg::ST_CELL: begin
            ctl.cell_en = 1'b1;
            state_in    = pfc_pkg::ST_SEND;
         end
         pfc_pkg::ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               state_in     = pfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[design/pfc_datapath.sv]
// playfair datapath: square and letter position memories, fill counters,
// placed flags, encrypt rules and result registers; depends on pfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfc_datapath #(
   parameter int GRID_SIDE = pfc_pkg::GRID_SIDE_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pfc_pkg::ctl_cmd_type            ctl,
   input  wire logic [pfc_pkg::LETTER_W-1:0]    req_letter_a,
   input  wire logic [pfc_pkg::LETTER_W-1:0]    req_letter_b,
   input  wire logic                            req_second_present,
   output pfc_pkg::dp_status_type               status,
   output logic [pfc_pkg::LETTER_W-1:0]         rsp_cipher_a,
   output logic [pfc_pkg::LETTER_W-1:0]         rsp_cipher_b,
   output logic                                 rsp_status
);

   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int RC_W       = $clog2(GRID_SIDE);
   localparam int POS_W      = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int LW         = pfc_pkg::LETTER_W;
   localparam int ALPHA      = pfc_pkg::ALPHA;

   typedef struct packed {
      logic [RC_W-1:0] row;
      logic [RC_W-1:0] col;
   } rc_type;

   // memories
   logic [LW-1:0] square_mem [CELL_COUNT];
   rc_type        index_mem  [ALPHA];

   logic [ALPHA-1:0] placed_ff, placed_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   rc_type           fill_rc_ff, fill_rc_in;
   logic             complete_ff, complete_in;
   logic [LW-1:0]    walk_ff, walk_in;

   rc_type        ia_ff, ib_ff;
   logic          err_ff;
   logic [LW-1:0] sa_ff, sb_ff;
   logic [LW-1:0] out_a_ff, out_b_ff;
   logic          out_err_ff;

   // placement
   logic             key_valid, restart, placed_key, do_place;
   logic [LW-1:0]    place_code;
   logic [CNT_W-1:0] base_fill;
   rc_type           base_rc;
   logic [POS_W-1:0] place_pos;

   always_comb begin
      key_valid  = ctl.key_en && (req_letter_a < LW'(ALPHA));
      restart    = key_valid && complete_ff;
      placed_key = restart ? 1'b0 : placed_ff[req_letter_a];
      base_fill  = restart ? '0 : fill_ff;
      base_rc    = restart ? '0 : fill_rc_ff;
      do_place   = 1'b0;
      place_code = req_letter_a;
      if (key_valid) begin
         do_place = (req_letter_a != pfc_pkg::CODE_J) && !placed_key
                    && (base_fill < CNT_W'(CELL_COUNT));
      end else if (ctl.fin_step) begin
         place_code = walk_ff;
         do_place   = (walk_ff != pfc_pkg::CODE_J) && !placed_ff[walk_ff]
                      && (fill_ff < CNT_W'(CELL_COUNT));
      end
      place_pos = POS_W'(base_rc.row * GRID_SIDE + base_rc.col);

      placed_in   = restart ? '0 : placed_ff;
      fill_in     = fill_ff;
      fill_rc_in  = base_rc;
      complete_in = complete_ff;
      walk_in     = walk_ff;
      if (restart) begin
         fill_in     = '0;
         complete_in = 1'b0;
      end
      if (do_place) begin
         placed_in[place_code] = 1'b1;
         fill_in               = base_fill + CNT_W'(1);
         if (base_rc.col == RC_W'(GRID_SIDE - 1)) begin
            fill_rc_in.col = '0;
            fill_rc_in.row = base_rc.row + RC_W'(1);
         end else begin
            fill_rc_in.col = base_rc.col + RC_W'(1);
         end
      end
      if (ctl.fin_start) begin
         walk_in = '0;
      end else if (ctl.fin_step) begin
         walk_in = walk_ff + LW'(1);
         if (walk_ff == LW'(ALPHA - 1)) begin
            complete_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         placed_ff   <= '0;
         fill_ff     <= '0;
         fill_rc_ff  <= '0;
         complete_ff <= 1'b0;
         walk_ff     <= '0;
      end else begin
         placed_ff   <= placed_in;
         fill_ff     <= fill_in;
         fill_rc_ff  <= fill_rc_in;
         complete_ff <= complete_in;
         walk_ff     <= walk_in;
      end
   end

   // letter position lookup
   logic [LW-1:0] addr_a, addr_b;

   always_comb begin
      addr_a = pfc_pkg::fold_letter(req_letter_a);
      addr_b = pfc_pkg::fold_letter(req_second_present ? req_letter_b : pfc_pkg::CODE_X);
   end

   always_ff @(posedge clock) begin
      if (do_place) begin
         index_mem[place_code] <= base_rc;
         square_mem[place_pos] <= place_code;
      end
      if (ctl.lookup_en) begin
         ia_ff  <= index_mem[addr_a];
         ib_ff  <= index_mem[addr_b];
         err_ff <= !complete_ff;
      end
   end

   // digraph rules
   rc_type           oa, ob;
   logic [POS_W-1:0] pos_a, pos_b;

   always_comb begin
      oa = ia_ff;
      ob = ib_ff;
      priority if (ia_ff.row == ib_ff.row) begin
         oa.col = (ia_ff.col == RC_W'(GRID_SIDE - 1)) ? '0 : ia_ff.col + RC_W'(1);
         ob.col = (ib_ff.col == RC_W'(GRID_SIDE - 1)) ? '0 : ib_ff.col + RC_W'(1);
      end else if (ia_ff.col == ib_ff.col) begin
         oa.row = (ia_ff.row == RC_W'(GRID_SIDE - 1)) ? '0 : ia_ff.row + RC_W'(1);
         ob.row = (ib_ff.row == RC_W'(GRID_SIDE - 1)) ? '0 : ib_ff.row + RC_W'(1);
      end else begin
         oa.col = ib_ff.col;
         ob.col = ia_ff.col;
      end
      pos_a = POS_W'(oa.row * GRID_SIDE + oa.col);
      pos_b = POS_W'(ob.row * GRID_SIDE + ob.col);
   end

   always_ff @(posedge clock) begin
      if (ctl.cell_en) begin
         sa_ff <= square_mem[pos_a];
         sb_ff <= square_mem[pos_b];
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         out_a_ff   <= err_ff ? '0 : sa_ff;
         out_b_ff   <= err_ff ? '0 : sb_ff;
         out_err_ff <= err_ff;
      end
   end

   assign status.complete = complete_ff;
   assign status.fin_last = (walk_ff == LW'(ALPHA - 1));
   assign rsp_cipher_a    = out_a_ff;
   assign rsp_cipher_b    = out_b_ff;
   assign rsp_status      = out_err_ff;

endmodule

`default_nettype wire

[sim/playfair_checker.sv]
`timescale 1ns / 1ps
// playfair checker: watches both channels of the cipher, keeps its own key
// square and compares each cipher word, in order, with the predicted one
// depends on pfc_pkg
module playfair_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [1:0]                   req_command,
   input  logic [pfc_pkg::LETTER_W-1:0] req_letter_a,
   input  logic [pfc_pkg::LETTER_W-1:0] req_letter_b,
   input  logic                         req_second_present,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [pfc_pkg::LETTER_W-1:0] rsp_cipher_a,
   input  logic [pfc_pkg::LETTER_W-1:0] rsp_cipher_b,
   input  logic                         rsp_status,
   output int                           mismatch_count,
   output int                           words_waiting,
   output int                           words_checked
);
   import pfc_pkg::*;

   localparam int SIDE  = GRID_SIDE_DEFAULT;
   localparam int CELLS = SIDE * SIDE;

   typedef struct packed {
      logic [LETTER_W-1:0] cipher_a;
      logic [LETTER_W-1:0] cipher_b;
      logic                status;
   } cipher_word_type;

   cipher_word_type     cipher_due[$];
   logic [LETTER_W-1:0] square_letter [CELLS];
   int                  letter_cell [ALPHA];
   logic [ALPHA-1:0]    letter_used;
   int                  cells_filled;
   logic                square_ready;

   initial begin
      foreach (square_letter[i]) square_letter[i] = '0;
      foreach (letter_cell[i]) letter_cell[i] = 0;
      letter_used    = '0;
      cells_filled   = 0;
      square_ready   = 1'b0;
      mismatch_count = 0;
      words_waiting  = 0;
      words_checked  = 0;
   end

   function automatic logic [LETTER_W-1:0] fold_code(input logic [LETTER_W-1:0] code);
      if (code == CODE_J) return CODE_I;
      if (code > CODE_Z) return CODE_Z;
      return code;
   endfunction

   task automatic place_letter(input logic [LETTER_W-1:0] code);
      if (cells_filled < CELLS) begin
         square_letter[cells_filled] = code;
         letter_cell[code]           = cells_filled;
         letter_used[code]           = 1'b1;
         cells_filled++;
      end
   endtask

   task automatic apply_command(input logic [1:0] cmd, input logic [LETTER_W-1:0] la,
                                input logic [LETTER_W-1:0] lb, input logic present);
      cipher_word_type     w;
      logic [LETTER_W-1:0] pa, pb;
      int                  ca, cb, ra, rb, oa, ob;
      case (cmd)
         CMD_KEY: begin
            if (la < ALPHA) begin
               // a key letter after completion starts a new square
               if (square_ready) begin
                  letter_used  = '0;
                  cells_filled = 0;
                  square_ready = 1'b0;
               end
               if (la != CODE_J && !letter_used[la]) place_letter(la);
            end
         end
         CMD_FINISH: begin
            if (!square_ready) begin
               for (int k = 0; k < ALPHA; k++)
                  if (k != CODE_J && !letter_used[k]) place_letter(k[LETTER_W-1:0]);
               square_ready = 1'b1;
            end
         end
         CMD_ENCRYPT: begin
            w = '0;
            if (!square_ready) begin
               w.status = 1'b1;
            end else begin
               pa = fold_code(la);
               pb = fold_code(present ? lb : CODE_X);
               ra = letter_cell[pa] / SIDE;
               ca = letter_cell[pa] % SIDE;
               rb = letter_cell[pb] / SIDE;
               cb = letter_cell[pb] % SIDE;
               if (ra == rb) begin
                  oa = ra * SIDE + (ca + 1) % SIDE;
                  ob = rb * SIDE + (cb + 1) % SIDE;
               end else if (ca == cb) begin
                  oa = ((ra + 1) % SIDE) * SIDE + ca;
                  ob = ((rb + 1) % SIDE) * SIDE + cb;
               end else begin
                  oa = ra * SIDE + cb;
                  ob = rb * SIDE + ca;
               end
               w.cipher_a = square_letter[oa];
               w.cipher_b = square_letter[ob];
            end
            cipher_due.push_back(w);
         end
         default: begin
         end
      endcase
   endtask

   // sampled on the falling edge ahead of the rising edge that completes each handshake
   always @(negedge clock) begin : watch
      cipher_word_type want;
      if (reset) begin
         cipher_due.delete();
         letter_used  = '0;
         cells_filled = 0;
         square_ready = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (cipher_due.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected cipher word a=%0d b=%0d status=%0d",
                           rsp_cipher_a, rsp_cipher_b, rsp_status);
               mismatch_count++;
            end else begin
               want = cipher_due.pop_front();
               if (want.cipher_a !== rsp_cipher_a || want.cipher_b !== rsp_cipher_b ||
                   want.status !== rsp_status) begin
                  if (mismatch_count < 10)
                     $display({"cipher word %0d: expected a=%0d b=%0d status=%0d,",
                               " got a=%0d b=%0d status=%0d"},
                              words_checked, want.cipher_a, want.cipher_b, want.status,
                              rsp_cipher_a, rsp_cipher_b, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            apply_command(req_command, req_letter_a, req_letter_b, req_second_present);
      end
      words_waiting = cipher_due.size();
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench top for the playfair digraph cipher: clock, reset, stimulus and
// verdict; depends on pfc_pkg, playfair_digraph_cipher and playfair_checker
module testbench;
   import pfc_pkg::*;

   localparam logic [1:0] CMD_NONE     = 2'd3;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         PHASE_ITEMS  = 325;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic [1:0]          req_command        = '0;
   logic [LETTER_W-1:0] req_letter_a       = '0;
   logic [LETTER_W-1:0] req_letter_b       = '0;
   logic                req_second_present = 1'b0;
   logic                rsp_ready          = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic [LETTER_W-1:0] rsp_cipher_a;
   logic [LETTER_W-1:0] rsp_cipher_b;
   logic                rsp_status;

   int mismatch_count;
   int words_waiting;
   int words_checked;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int items_sent    = 0;
   int sessions      = 0;
   int cycle_count   = 0;

   playfair_digraph_cipher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_letter_a       (req_letter_a),
      .req_letter_b       (req_letter_b),
      .req_second_present (req_second_present),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cipher_a       (rsp_cipher_a),
      .rsp_cipher_b       (rsp_cipher_b),
      .rsp_status         (rsp_status)
   );

   playfair_checker cipher_watch (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_letter_a       (req_letter_a),
      .req_letter_b       (req_letter_b),
      .req_second_present (req_second_present),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cipher_a       (rsp_cipher_a),
      .rsp_cipher_b       (rsp_cipher_b),
      .rsp_status         (rsp_status),
      .mismatch_count     (mismatch_count),
      .words_waiting      (words_waiting),
      .words_checked      (words_checked)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served < hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   function automatic logic [LETTER_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return LETTER_W'($urandom_range(ALPHA, 31));
      if (roll < 13) return CODE_J;
      return LETTER_W'($urandom_range(0, ALPHA - 1));
   endfunction

   function automatic logic [LETTER_W-1:0] pick_plain();
      if ($urandom_range(0, 99) < 8) return LETTER_W'($urandom_range(ALPHA, 31));
      return LETTER_W'($urandom_range(0, ALPHA - 1));
   endfunction

   task automatic send_word(input logic [1:0] cmd, input logic [LETTER_W-1:0] la,
                            input logic [LETTER_W-1:0] lb, input logic present);
      logic took;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_letter_a       <= la;
      req_letter_b       <= lb;
      req_second_present <= present;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end
      if (!(cmd == CMD_NONE || (cmd == CMD_KEY && la >= ALPHA))) items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
   endtask

   task automatic run_session();
      int n_key;
      int n_enc;
      n_key = $urandom_range(0, 30);
      repeat (n_key) begin
         if ($urandom_range(0, 19) == 0)
            send_word(CMD_NONE, pick_plain(), pick_plain(), 1'($urandom_range(0, 1)));
         else
            send_word(CMD_KEY, pick_key(), pick_plain(), 1'($urandom_range(0, 1)));
      end
      // broken sequences: early encrypt, missing or repeated finish
      if ($urandom_range(0, 9) == 0)
         send_word(CMD_ENCRYPT, pick_plain(), pick_plain(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 19) != 0)
         send_word(CMD_FINISH, pick_plain(), pick_plain(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0)
         send_word(CMD_FINISH, pick_plain(), pick_plain(), 1'($urandom_range(0, 1)));
      n_enc = $urandom_range(4, 24);
      repeat (n_enc)
         send_word(CMD_ENCRYPT, pick_plain(), pick_plain(), $urandom_range(0, 99) < 85);
      sessions++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(CMD_ENCRYPT, 5'd25, 5'd31, 1'b1);
      send_word(CMD_NONE, 5'd31, 5'd31, 1'b1);
      send_word(CMD_KEY, 5'd31, 5'd0, 1'b0);
      send_word(CMD_KEY, CODE_J, 5'd31, 1'b1);
      send_word(CMD_KEY, 5'd15, 5'd0, 1'b0);
      send_word(CMD_KEY, 5'd11, 5'd0, 1'b0);
      send_word(CMD_KEY, 5'd0, 5'd0, 1'b0);
      send_word(CMD_KEY, 5'd24, 5'd0, 1'b0);
      send_word(CMD_KEY, 5'd5, 5'd0, 1'b0);
      send_word(CMD_KEY, 5'd0, 5'd0, 1'b0);
      send_word(CMD_KEY, CODE_I, 5'd0, 1'b0);
      send_word(CMD_KEY, 5'd17, 5'd0, 1'b0);
      send_word(CMD_ENCRYPT, 5'd0, 5'd1, 1'b1);
      send_word(CMD_FINISH, 5'd0, 5'd0, 1'b0);
      send_word(CMD_FINISH, 5'd31, 5'd31, 1'b1);
      send_word(CMD_ENCRYPT, 5'd0, 5'd0, 1'b1);
      send_word(CMD_ENCRYPT, CODE_J, CODE_I, 1'b1);
      send_word(CMD_ENCRYPT, 5'd31, CODE_Z, 1'b1);
      send_word(CMD_ENCRYPT, 5'd15, 5'd31, 1'b0);
      send_word(CMD_ENCRYPT, CODE_X, 5'd0, 1'b0);
      send_word(CMD_ENCRYPT, 5'd15, 5'd11, 1'b1);
      send_word(CMD_ENCRYPT, 5'd15, CODE_I, 1'b1);
      send_word(CMD_ENCRYPT, 5'd11, 5'd17, 1'b1);
      send_word(CMD_KEY, CODE_Z, 5'd0, 1'b0);
      send_word(CMD_FINISH, 5'd0, 5'd0, 1'b0);
      send_word(CMD_ENCRYPT, CODE_Z, 5'd0, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin req_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         while (items_sent < 26 + PHASE_ITEMS * (phase + 1)) begin
            if (phase == 0 && hold_requests == 0 && sessions > 0) hold_requests++;
            run_session();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d command words in %0d key sessions over four idle mixes,",
               items_sent, sessions);
      $display("%0d cipher words checked", words_checked);
      $display("receiver held off %0d cycles once with the request side backed up", HOLD_CYCLES);
      if (mismatch_count == 0 && words_waiting == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d cipher words never arrived", mismatch_count, words_waiting);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
design/pfc_pkg.sv
design/pfc_ctrl.sv
design/pfc_datapath.sv
design/playfair_digraph_cipher.sv
sim/playfair_checker.sv
sim/testbench.sv
